// ----- src/dest_pkg.sv -----
// ----------------------------------------------------------------------------
// dest_pkg
// Types and constants shared by the delayed event slot table modules.
// ----------------------------------------------------------------------------
package dest_pkg;

	// field widths
	localparam int FRAME_W = 64;
	localparam int BYTE_W  = 8;
	localparam int CNT_W   = 7;

	// most events one take can emit
	localparam int MAX_EMIT = 64;

	// operation codes
	typedef enum logic [2:0] {
		OP_SCHEDULE  = 3'd0,
		OP_CANCEL_TR = 3'd1,
		OP_CANCEL_VC = 3'd2,
		OP_CANCEL_AL = 3'd3,
		OP_QUERY     = 3'd4,
		OP_NEXT_DUE  = 3'd5,
		OP_TAKE_DUE  = 3'd6,
		OP_COUNT     = 3'd7
	} op_t;

	// sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_EMIT,
		S_FIN
	} state_t;

	// contents of one slot
	typedef struct packed {
		logic               pending;
		logic [FRAME_W-1:0] due;
		logic [BYTE_W-1:0]  voice;
		logic [BYTE_W-1:0]  note;
	} slot_t;

	// command applied to the slot at the head of the row
	typedef struct packed {
		op_t                op;
		logic               match;
		logic               take_clear;
		logic [FRAME_W-1:0] frame;
		logic [FRAME_W-1:0] wend;
		logic [BYTE_W-1:0]  voice;
		logic [BYTE_W-1:0]  note;
	} cmd_t;

	// status of the head slot
	typedef struct packed {
		logic due_hit;
		logic win_hit;
	} flags_t;

endpackage

// ----- src/dest_cell.sv -----
// ----------------------------------------------------------------------------
// dest_cell
// One slot of the circulating row; takes its neighbor's slot on each shift.
// ----------------------------------------------------------------------------
module dest_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            shift,
	input  dest_pkg::slot_t din,
	output dest_pkg::slot_t q
);

	// slot register, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (shift) begin
			q <= din;
		end
	end

endmodule

// ----- src/dest_slot_unit.sv -----
// ----------------------------------------------------------------------------
// dest_slot_unit
// Applies the current operation to the head slot and reports its status.
// ----------------------------------------------------------------------------
module dest_slot_unit (
	input  dest_pkg::slot_t  head,
	input  dest_pkg::cmd_t   cmd,
	output dest_pkg::slot_t  next_slot,
	output dest_pkg::flags_t flags
);

	logic due_le_frame;
	logic due_le_wend;

	// frame compares
	assign due_le_frame = (head.due <= cmd.frame);
	assign due_le_wend  = (head.due <= cmd.wend);

	assign flags.due_hit = head.pending && due_le_frame;
	assign flags.win_hit = head.pending && !due_le_frame && due_le_wend;

	// updated slot written back at the tail of the row
	always_comb begin
		next_slot = head;
		unique case (cmd.op)
			dest_pkg::OP_SCHEDULE: begin
				if (cmd.match) begin
					next_slot.pending = 1'b1;
					next_slot.due     = cmd.frame;
					next_slot.voice   = cmd.voice;
					next_slot.note    = cmd.note;
				end
			end
			dest_pkg::OP_CANCEL_TR: begin
				if (cmd.match) next_slot = '0;
			end
			dest_pkg::OP_CANCEL_VC: begin
				if (head.pending && head.voice == cmd.voice) next_slot = '0;
			end
			dest_pkg::OP_CANCEL_AL: begin
				next_slot = '0;
			end
			dest_pkg::OP_TAKE_DUE: begin
				if (cmd.take_clear && flags.due_hit) next_slot = '0;
			end
			default: begin
				next_slot = head;
			end
		endcase
	end

endmodule

// ----- src/delayed_event_slot_table.sv -----
// ----------------------------------------------------------------------------
// delayed_event_slot_table
// Slot table of pending delayed note events, one slot per track, held in a
// row of cells that circulates past a single head unit.
// ----------------------------------------------------------------------------
// Timing: the result word of an item is registered once the row has passed
//   the head unit in full; take due scans twice and emits its words during
//   the second pass, which an output stall can hold.
// Flow: a new item is taken only while idle; the row of slot cells passes
//   the head unit one slot per cycle unless the output stalls.
// Reset: arst_n clears every slot and the control state at once.
module delayed_event_slot_table #(
	parameter int NUM_SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  opcode,
	input  logic [7:0]  track,
	input  logic [63:0] frame_value,
	input  logic [63:0] window_end,
	input  logic [7:0]  voice,
	input  logic [7:0]  note,
	input  logic [6:0]  take_limit,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        found,
	output logic [7:0]  out_track,
	output logic [63:0] out_frame,
	output logic [7:0]  out_voice,
	output logic [7:0]  out_note,
	output logic [6:0]  count,
	output logic        last
);

	localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CW = dest_pkg::CNT_W;

	dest_pkg::state_t state_q, state_d;
	dest_pkg::slot_t  cell_q [NUM_SLOTS];
	dest_pkg::slot_t  next_slot;
	dest_pkg::flags_t flags;
	dest_pkg::cmd_t   cmd;

	// latched command
	dest_pkg::op_t               op_q;
	logic [7:0]                  track_q;
	logic [dest_pkg::FRAME_W-1:0] frame_q;
	logic [dest_pkg::FRAME_W-1:0] wend_q;
	logic [7:0]                  voice_q;
	logic [7:0]                  note_q;
	logic [CW-1:0]               lim_q;

	// scan state
	logic [IW-1:0] idx_q;
	logic          idx_last;
	logic [CW-1:0] acc_q;
	logic [CW-1:0] nemit_q;
	logic [CW-1:0] emit_q;
	logic          hit_q;
	logic [7:0]    res_track_q;
	logic [63:0]   res_frame_q;
	logic [7:0]    res_voice_q;
	logic [7:0]    res_note_q;

	// sequencer controls
	logic shift;
	logic want;
	logic stall;
	logic load_emit;
	logic load_fin;
	logic accept;
	logic out_valid_q;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == dest_pkg::S_IDLE);
	assign idx_last = (idx_q == IW'(NUM_SLOTS - 1));

	// row of slot cells, head at index zero, written back at the tail
	for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
		if (i == NUM_SLOTS - 1) begin : g_tail
			dest_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (shift),
				.din    (next_slot),
				.q      (cell_q[i])
			);
		end else begin : g_mid
			dest_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (shift),
				.din    (cell_q[i+1]),
				.q      (cell_q[i])
			);
		end
	end

	// command seen by the head unit
	always_comb begin
		cmd.op         = op_q;
		cmd.match      = (track_q < 8'(NUM_SLOTS)) && (track_q == 8'(idx_q));
		cmd.take_clear = (state_q == dest_pkg::S_EMIT);
		cmd.frame      = frame_q;
		cmd.wend       = wend_q;
		cmd.voice      = voice_q;
		cmd.note       = note_q;
	end

	dest_slot_unit u_slot_unit (
		.head      (cell_q[0]),
		.cmd       (cmd),
		.next_slot (next_slot),
		.flags     (flags)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dest_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and controls
	always_comb begin
		state_d   = state_q;
		shift     = 1'b0;
		want      = 1'b0;
		stall     = 1'b0;
		load_emit = 1'b0;
		load_fin  = 1'b0;
		unique case (state_q)
			dest_pkg::S_IDLE: begin
				if (in_valid) state_d = dest_pkg::S_SCAN;
			end
			dest_pkg::S_SCAN: begin
				shift = 1'b1;
				if (idx_last) begin
					state_d = (op_q == dest_pkg::OP_TAKE_DUE) ? dest_pkg::S_EMIT
						: dest_pkg::S_FIN;
				end
			end
			dest_pkg::S_EMIT: begin
				want      = flags.due_hit && (emit_q < nemit_q);
				stall     = want && out_valid_q && !out_ready;
				shift     = !stall;
				load_emit = want && !stall;
				if (!stall && idx_last) begin
					state_d = (nemit_q == '0) ? dest_pkg::S_FIN : dest_pkg::S_IDLE;
				end
			end
			dest_pkg::S_FIN: begin
				if (!out_valid_q || out_ready) begin
					load_fin = 1'b1;
					state_d  = dest_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = dest_pkg::S_IDLE;
			end
		endcase
	end

	// command latch
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= dest_pkg::op_t'(opcode);
			track_q <= track;
			frame_q <= frame_value;
			wend_q  <= window_end;
			voice_q <= voice;
			note_q  <= note;
			lim_q   <= (take_limit > CW'(dest_pkg::MAX_EMIT)) ? CW'(dest_pkg::MAX_EMIT)
				: take_limit;
		end
	end

	// scan counters and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			acc_q   <= '0;
			nemit_q <= '0;
			emit_q  <= '0;
			hit_q   <= 1'b0;
		end else begin
			if (accept) begin
				idx_q <= '0;
				acc_q <= '0;
				hit_q <= 1'b0;
			end else if (shift) begin
				idx_q <= idx_last ? '0 : idx_q + 1'b1;
			end
			if (state_q == dest_pkg::S_SCAN) begin
				if (op_q == dest_pkg::OP_TAKE_DUE) begin
					acc_q <= acc_q + CW'(flags.due_hit);
				end else begin
					acc_q <= acc_q + CW'(next_slot.pending);
				end
				if (op_q == dest_pkg::OP_QUERY && cmd.match && cell_q[0].pending) begin
					hit_q <= 1'b1;
				end
				if (op_q == dest_pkg::OP_NEXT_DUE && flags.win_hit
					&& (!hit_q || cell_q[0].due < res_frame_q)) begin
					hit_q <= 1'b1;
				end
				if (idx_last) begin
					nemit_q <= (acc_q + CW'(flags.due_hit) < lim_q)
						? acc_q + CW'(flags.due_hit) : lim_q;
					emit_q  <= '0;
				end
			end
			if (load_emit) emit_q <= emit_q + 1'b1;
		end
	end

	// captured report fields for query and next due
	always_ff @(posedge clk) begin
		if (accept) begin
			res_track_q <= '0;
			res_frame_q <= '0;
			res_voice_q <= '0;
			res_note_q  <= '0;
		end else if (state_q == dest_pkg::S_SCAN) begin
			if (op_q == dest_pkg::OP_QUERY && cmd.match && cell_q[0].pending) begin
				res_track_q <= track_q;
				res_frame_q <= cell_q[0].due;
				res_voice_q <= cell_q[0].voice;
				res_note_q  <= cell_q[0].note;
			end
			if (op_q == dest_pkg::OP_NEXT_DUE && flags.win_hit
				&& (!hit_q || cell_q[0].due < res_frame_q)) begin
				res_frame_q <= cell_q[0].due;
			end
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_emit || load_fin) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_emit) begin
			found     <= 1'b1;
			out_track <= 8'(idx_q);
			out_frame <= cell_q[0].due;
			out_voice <= cell_q[0].voice;
			out_note  <= cell_q[0].note;
			count     <= acc_q;
			last      <= (emit_q + 1'b1 == nemit_q);
		end else if (load_fin) begin
			found     <= hit_q;
			out_track <= res_track_q;
			out_frame <= res_frame_q;
			out_voice <= res_voice_q;
			out_note  <= res_note_q;
			count     <= acc_q;
			last      <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	// an accepted word always starts a scan
	a_accept_scan: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == dest_pkg::S_SCAN)
		else $error("accepted word did not start a scan");

	// head index stays inside the row
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= IW'(NUM_SLOTS - 1))
		else $error("head index out of range");

	// take never emits more words than planned
	a_emit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dest_pkg::S_EMIT) |-> emit_q <= nemit_q)
		else $error("take emitted too many words");

	// count never exceeds the slot total
	a_acc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		acc_q <= CW'(NUM_SLOTS))
		else $error("slot count overflow");

	// a word is never loaded over one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(load_emit || load_fin) |-> (!out_valid_q || out_ready))
		else $error("output word overwritten");
`endif

endmodule
